>>> hw/rtl/thin_lens_particle_deflect_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thin-lens deflection block
// Each macro expects signals named clk and rst in the scope that uses it.
// ----------------------------------------------------------------------------
`ifndef THIN_LENS_PARTICLE_DEFLECT_ASSERT_SVH
`define THIN_LENS_PARTICLE_DEFLECT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define TLPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define TLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tlpd_pkg.sv
// ----------------------------------------------------------------------------
// tlpd_pkg
// Shared widths, types and arithmetic steps of the thin-lens deflection block.
// ----------------------------------------------------------------------------
package tlpd_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = DATA_WIDTH - 8;
  localparam int NUM_WIDTH   = DATA_WIDTH + FRAC_BITS;
  localparam int SQ_WIDTH    = 2 * DATA_WIDTH;
  localparam int SCALED_W    = SQ_WIDTH - FRAC_BITS;
  localparam int DIV_STEPS   = DATA_WIDTH;
  localparam int ROOT_STEPS  = DATA_WIDTH;
  // input, setup, divide+root, finish/sub/square, root, divide, clamp/mul/out
  localparam int PIPE_DEPTH  = 2 + (DIV_STEPS + 1) + 3 + (ROOT_STEPS + 1) +
                               (DIV_STEPS + 1) + 3;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [DATA_WIDTH-1:0]        mag_t;
  typedef logic [SQ_WIDTH-1:0]          sq_t;
  typedef logic [SCALED_W-1:0]          scaled_t;

  typedef enum logic [1:0] {
    FAULT_OK      = 2'd0,
    FAULT_ZERO_VZ = 2'd1,
    FAULT_ZERO_F  = 2'd2,
    FAULT_SAT     = 2'd3
  } fault_t;

  localparam word_t WORD_MAX    = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN    = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t FOCAL_RESET = word_t'({1'b1, {FRAC_BITS{1'b0}}});
  localparam sq_t   ONE_SQ      = sq_t'({1'b1, {(2*FRAC_BITS){1'b0}}});

  // Restoring divider state: numerator bits still to shift in, magnitudes.
  typedef struct packed {
    logic [NUM_WIDTH-1:0] num;
    mag_t                 den;
    mag_t                 rem;
    mag_t                 quo;
    logic                 neg;
    logic                 ovf;
  } div_t;

  // Digit-by-digit square root state, two radicand bits per step.
  typedef struct packed {
    sq_t                   x;
    logic [DATA_WIDTH+1:0] rem;
    mag_t                  root;
  } sqr_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } satw_t;

  typedef struct packed {
    logic zvz;
    logic zf;
    logic sat;
  } flags_t;

  function automatic mag_t abs_mag(word_t v);
    return v[DATA_WIDTH-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  function automatic sq_t mul_mag(mag_t a, mag_t b);
    return {{DATA_WIDTH{1'b0}}, a} * {{DATA_WIDTH{1'b0}}, b};
  endfunction

  // Quotient (a << FRAC_BITS) / b; flag the case where it needs more bits.
  function automatic div_t div_setup(mag_t a, mag_t b, logic neg);
    div_t d;
    d.num = {a, {FRAC_BITS{1'b0}}};
    d.den = b;
    d.rem = mag_t'(d.num[NUM_WIDTH-1:DATA_WIDTH]);
    d.quo = '0;
    d.neg = neg;
    d.ovf = (mag_t'(d.num[NUM_WIDTH-1:DATA_WIDTH]) >= b);
    d.num = d.num << FRAC_BITS;
    return d;
  endfunction

  // One quotient bit.
  function automatic div_t div_step(div_t d);
    div_t                o;
    logic [DATA_WIDTH:0] t;
    logic [DATA_WIDTH:0] diff;
    o     = d;
    t     = {d.rem, d.num[NUM_WIDTH-1]};
    diff  = t - {1'b0, d.den};
    o.num = d.num << 1;
    if (t >= {1'b0, d.den}) begin
      o.rem = diff[DATA_WIDTH-1:0];
      o.quo = {d.quo[DATA_WIDTH-2:0], 1'b1};
    end else begin
      o.rem = t[DATA_WIDTH-1:0];
      o.quo = {d.quo[DATA_WIDTH-2:0], 1'b0};
    end
    return o;
  endfunction

  // Apply sign and clamp to the signed word range.
  function automatic satw_t div_finish(div_t d);
    satw_t r;
    r.sat = 1'b0;
    r.val = word_t'(d.quo);
    if (d.ovf) begin
      r.sat = 1'b1;
      r.val = d.neg ? WORD_MIN : WORD_MAX;
    end else if (!d.neg) begin
      if (d.quo[DATA_WIDTH-1]) begin
        r.sat = 1'b1;
        r.val = WORD_MAX;
      end
    end else if (d.quo > mag_t'(WORD_MIN)) begin
      r.sat = 1'b1;
      r.val = WORD_MIN;
    end else begin
      r.val = word_t'(-d.quo);
    end
    return r;
  endfunction

  function automatic satw_t sat_sub(word_t a, word_t b);
    satw_t               r;
    logic [DATA_WIDTH:0] t;
    t     = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    r.sat = (t[DATA_WIDTH] != t[DATA_WIDTH-1]);
    r.val = r.sat ? (t[DATA_WIDTH] ? WORD_MIN : WORD_MAX) : word_t'(t[DATA_WIDTH-1:0]);
    return r;
  endfunction

  function automatic sqr_t sqrt_init(sq_t x);
    sqr_t s;
    s.x    = x;
    s.rem  = '0;
    s.root = '0;
    return s;
  endfunction

  // One root bit.
  function automatic sqr_t sqrt_step(sqr_t s);
    sqr_t                  o;
    logic [DATA_WIDTH+3:0] t;
    logic [DATA_WIDTH+3:0] trial;
    logic [DATA_WIDTH+3:0] diff;
    o     = s;
    t     = {s.rem, s.x[SQ_WIDTH-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    diff  = t - trial;
    o.x   = s.x << 2;
    if (t >= trial) begin
      o.rem  = diff[DATA_WIDTH+1:0];
      o.root = {s.root[DATA_WIDTH-2:0], 1'b1};
    end else begin
      o.rem  = t[DATA_WIDTH+1:0];
      o.root = {s.root[DATA_WIDTH-2:0], 1'b0};
    end
    return o;
  endfunction

  // Drop fraction bits of |n|*vz, restore sign, clamp.
  function automatic satw_t scale_finish(sq_t prod, logic neg);
    satw_t   r;
    scaled_t q;
    q     = prod[SQ_WIDTH-1:FRAC_BITS];
    r.sat = 1'b0;
    if (!neg) begin
      if (q > scaled_t'(mag_t'(WORD_MAX))) begin
        r.sat = 1'b1;
        r.val = WORD_MAX;
      end else begin
        r.val = word_t'(q[DATA_WIDTH-1:0]);
      end
    end else if (q > scaled_t'(mag_t'(WORD_MIN))) begin
      r.sat = 1'b1;
      r.val = WORD_MIN;
    end else begin
      r.val = word_t'(-q[DATA_WIDTH-1:0]);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/tlpd_in_if.sv
// ----------------------------------------------------------------------------
// tlpd_in_if
// Particle item channel: position and velocity with valid/ready.
// ----------------------------------------------------------------------------
interface tlpd_in_if import tlpd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t pos_x;
  word_t pos_y;
  word_t vel_x;
  word_t vel_y;
  word_t vel_z;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, vel_z, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, vel_z, output ready);
endinterface

>>> hw/rtl/tlpd_out_if.sv
// ----------------------------------------------------------------------------
// tlpd_out_if
// Deflected velocity item channel with fault code and valid/ready.
// ----------------------------------------------------------------------------
interface tlpd_out_if import tlpd_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      new_vel_x;
  word_t      new_vel_y;
  word_t      new_vel_z;
  logic [1:0] fault;

  modport source (output valid, new_vel_x, new_vel_y, new_vel_z, fault, input ready);
  modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, fault, output ready);
endinterface

>>> hw/rtl/thin_lens_particle_deflect.sv
// ----------------------------------------------------------------------------
// thin_lens_particle_deflect
// Velocity of a particle after a thin lens, fully pipelined, Q8.24.
// ----------------------------------------------------------------------------
// Usage:
//   particle  : input items (pos_x, pos_y, vel_x, vel_y, vel_z), valid/ready.
//   deflected : result items (new_vel_x, new_vel_y, new_vel_z, fault).
//   cfg_wr_en / cfg_wr_data write focal_length; write it only while idle.
// Throughput: one item per cycle while the output is not stalled. PIPE_DEPTH
//   is set mostly by three bit-serial chains in series: the four slope dividers
//   (alongside the speed square root), the slope-norm square root and the
//   final divider, each one bit per stage.
// Reset clears all stage valid bits and loads focal_length with 1.0.
// When the receiver holds ready low with a result waiting, the whole pipe
//   freezes and particle.ready drops; nothing is lost or repeated.
// Fault 1 (zero vel_z) wins over fault 2 (zero focal length); both give zero
//   velocities. Any clamped intermediate gives fault 3 with clamped values.
// ----------------------------------------------------------------------------
module thin_lens_particle_deflect import tlpd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  word_t         cfg_wr_data,
  tlpd_in_if.sink       particle,
  tlpd_out_if.source    deflected
);

  typedef struct packed {
    div_t   dvx;
    div_t   dvy;
    div_t   dpx;
    div_t   dpy;
    sqr_t   rs;
    flags_t fl;
  } slope_t;

  typedef struct packed {
    sqr_t   rm;
    word_t  nx;
    word_t  ny;
    mag_t   ss;
    flags_t fl;
  } norm_t;

  typedef struct packed {
    div_t   dz;
    word_t  nx;
    word_t  ny;
    flags_t fl;
  } axial_t;

  function automatic slope_t slope_step(slope_t c);
    slope_t o;
    o     = c;
    o.dvx = div_step(c.dvx);
    o.dvy = div_step(c.dvy);
    o.dpx = div_step(c.dpx);
    o.dpy = div_step(c.dpy);
    o.rs  = sqrt_step(c.rs);
    return o;
  endfunction

  logic                  advance;
  logic [PIPE_DEPTH-1:0] vld;
  word_t                 focal_length;

  word_t  px0, py0, vx0, vy0, vz0, f0;
  div_t   dvx1, dvy1, dpx1, dpy1;
  sq_t    sqx1, sqy1, sqz1;
  flags_t fl1;
  slope_t cs [DIV_STEPS+1];
  word_t  qx3, qy3, rx3, ry3;
  mag_t   ss3;
  flags_t fl3;
  word_t  nx4, ny4;
  mag_t   ss4;
  flags_t fl4;
  sq_t    nx2_5, ny2_5;
  word_t  nx5, ny5;
  mag_t   ss5;
  flags_t fl5;
  norm_t  es [ROOT_STEPS+1];
  axial_t hs [DIV_STEPS+1];
  word_t  vz8, nx8, ny8;
  flags_t fl8;
  sq_t    prx9, pry9;
  logic   nxneg9, nyneg9;
  word_t  vz9;
  flags_t fl9;

  satw_t  qx_fin, qy_fin, rx_fin, ry_fin, nx_sub, ny_sub, sx_fin, sy_fin;
  word_t  vel_x_next, vel_y_next, vel_z_next;
  fault_t fault_next;

  // Freeze everything while a result waits on the receiver.
  assign advance        = !vld[PIPE_DEPTH-1] || deflected.ready;
  assign particle.ready = advance;
  assign deflected.valid = vld[PIPE_DEPTH-1];

  // Focal length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_length <= FOCAL_RESET;
    end else if (cfg_wr_en) begin
      focal_length <= cfg_wr_data;
    end
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[PIPE_DEPTH-2:0], particle.valid};
    end
  end

  // Capture the item and the lens setting.
  always_ff @(posedge clk) begin
    if (advance) begin
      px0 <= particle.pos_x;
      py0 <= particle.pos_y;
      vx0 <= particle.vel_x;
      vy0 <= particle.vel_y;
      vz0 <= particle.vel_z;
      f0  <= focal_length;
    end
  end

  // Set up the four slope dividers and square the velocity components.
  always_ff @(posedge clk) begin
    if (advance) begin
      dvx1 <= div_setup(abs_mag(vx0), abs_mag(vz0), vx0[DATA_WIDTH-1] ^ vz0[DATA_WIDTH-1]);
      dvy1 <= div_setup(abs_mag(vy0), abs_mag(vz0), vy0[DATA_WIDTH-1] ^ vz0[DATA_WIDTH-1]);
      dpx1 <= div_setup(abs_mag(px0), abs_mag(f0), px0[DATA_WIDTH-1] ^ f0[DATA_WIDTH-1]);
      dpy1 <= div_setup(abs_mag(py0), abs_mag(f0), py0[DATA_WIDTH-1] ^ f0[DATA_WIDTH-1]);
      sqx1 <= mul_mag(abs_mag(vx0), abs_mag(vx0));
      sqy1 <= mul_mag(abs_mag(vy0), abs_mag(vy0));
      sqz1 <= mul_mag(abs_mag(vz0), abs_mag(vz0));
      fl1  <= '{zvz: (vz0 == '0), zf: (f0 == '0), sat: 1'b0};
    end
  end

  // Sum the speed squared (wraps at SQ_WIDTH bits) and start its root.
  always_ff @(posedge clk) begin
    if (advance) begin
      cs[0] <= '{dvx: dvx1, dvy: dvy1, dpx: dpx1, dpy: dpy1,
                 rs: sqrt_init(sqx1 + sqy1 + sqz1), fl: fl1};
    end
  end

  // Divide and take the speed root, one bit per stage.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_slope
    always_ff @(posedge clk) begin
      if (advance) begin
        cs[k+1] <= slope_step(cs[k]);
      end
    end
  end

  // Sign and clamp the four quotients.
  always_comb begin
    qx_fin = div_finish(cs[DIV_STEPS].dvx);
    qy_fin = div_finish(cs[DIV_STEPS].dvy);
    rx_fin = div_finish(cs[DIV_STEPS].dpx);
    ry_fin = div_finish(cs[DIV_STEPS].dpy);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      qx3 <= qx_fin.val;
      qy3 <= qy_fin.val;
      rx3 <= rx_fin.val;
      ry3 <= ry_fin.val;
      ss3 <= cs[DIV_STEPS].rs.root;
      fl3 <= '{zvz: cs[DIV_STEPS].fl.zvz, zf: cs[DIV_STEPS].fl.zf,
               sat: qx_fin.sat | qy_fin.sat | rx_fin.sat | ry_fin.sat};
    end
  end

  // Slopes: direction term minus lens term.
  always_comb begin
    nx_sub = sat_sub(qx3, rx3);
    ny_sub = sat_sub(qy3, ry3);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      nx4 <= nx_sub.val;
      ny4 <= ny_sub.val;
      ss4 <= ss3;
      fl4 <= '{zvz: fl3.zvz, zf: fl3.zf, sat: fl3.sat | nx_sub.sat | ny_sub.sat};
    end
  end

  // Square the slopes.
  always_ff @(posedge clk) begin
    if (advance) begin
      nx2_5 <= mul_mag(abs_mag(nx4), abs_mag(nx4));
      ny2_5 <= mul_mag(abs_mag(ny4), abs_mag(ny4));
      nx5   <= nx4;
      ny5   <= ny4;
      ss5   <= ss4;
      fl5   <= fl4;
    end
  end

  // Form 1 + |n|^2 and start its root.
  always_ff @(posedge clk) begin
    if (advance) begin
      es[0] <= '{rm: sqrt_init(nx2_5 + ny2_5 + ONE_SQ), nx: nx5, ny: ny5,
                 ss: ss5, fl: fl5};
    end
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_norm
    always_ff @(posedge clk) begin
      if (advance) begin
        es[k+1] <= '{rm: sqrt_step(es[k].rm), nx: es[k].nx, ny: es[k].ny,
                     ss: es[k].ss, fl: es[k].fl};
      end
    end
  end

  // Axial speed: speed / norm root, one bit per stage.
  always_ff @(posedge clk) begin
    if (advance) begin
      hs[0] <= '{dz: div_setup(es[ROOT_STEPS].ss, es[ROOT_STEPS].rm.root, 1'b0),
                 nx: es[ROOT_STEPS].nx, ny: es[ROOT_STEPS].ny,
                 fl: es[ROOT_STEPS].fl};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_axial
    always_ff @(posedge clk) begin
      if (advance) begin
        hs[k+1] <= '{dz: div_step(hs[k].dz), nx: hs[k].nx, ny: hs[k].ny,
                     fl: hs[k].fl};
      end
    end
  end

  // Clamp the axial speed; it is never negative.
  always_ff @(posedge clk) begin
    if (advance) begin
      vz8 <= hs[DIV_STEPS].dz.quo[DATA_WIDTH-1] ? WORD_MAX : word_t'(hs[DIV_STEPS].dz.quo);
      nx8 <= hs[DIV_STEPS].nx;
      ny8 <= hs[DIV_STEPS].ny;
      fl8 <= '{zvz: hs[DIV_STEPS].fl.zvz, zf: hs[DIV_STEPS].fl.zf,
               sat: hs[DIV_STEPS].fl.sat | hs[DIV_STEPS].dz.quo[DATA_WIDTH-1]};
    end
  end

  // Scale the slopes by the axial speed.
  always_ff @(posedge clk) begin
    if (advance) begin
      prx9   <= mul_mag(abs_mag(nx8), mag_t'(vz8));
      pry9   <= mul_mag(abs_mag(ny8), mag_t'(vz8));
      nxneg9 <= nx8[DATA_WIDTH-1];
      nyneg9 <= ny8[DATA_WIDTH-1];
      vz9    <= vz8;
      fl9    <= fl8;
    end
  end

  // Final clamp and fault selection.
  always_comb begin
    sx_fin     = scale_finish(prx9, nxneg9);
    sy_fin     = scale_finish(pry9, nyneg9);
    vel_x_next = sx_fin.val;
    vel_y_next = sy_fin.val;
    vel_z_next = vz9;
    fault_next = (fl9.sat | sx_fin.sat | sy_fin.sat) ? FAULT_SAT : FAULT_OK;
    if (fl9.zvz) begin
      vel_x_next = '0;
      vel_y_next = '0;
      vel_z_next = '0;
      fault_next = FAULT_ZERO_VZ;
    end else if (fl9.zf) begin
      vel_x_next = '0;
      vel_y_next = '0;
      vel_z_next = '0;
      fault_next = FAULT_ZERO_F;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      deflected.new_vel_x <= vel_x_next;
      deflected.new_vel_y <= vel_y_next;
      deflected.new_vel_z <= vel_z_next;
      deflected.fault     <= fault_next;
    end
  end

endmodule

>>> hw/rtl/tlpd_checker.sv
// ----------------------------------------------------------------------------
// tlpd_checker
// Port-level checks of the thin-lens deflection block, bound to the top.
// ----------------------------------------------------------------------------
`include "thin_lens_particle_deflect_assert.svh"

module tlpd_checker import tlpd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input word_t      new_vel_x,
  input word_t      new_vel_y,
  input word_t      new_vel_z,
  input logic [1:0] fault
);

  // Hold a refused result.
  `TLPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // Take items whenever the output side can move.
  `TLPD_ASSERT_NOW(a_in_open, !out_valid || out_ready, in_ready, "input refused with free output")

  // Axial velocity is never negative.
  `TLPD_ASSERT_NOW(a_vz_sign, out_valid, !new_vel_z[DATA_WIDTH-1], "negative axial velocity")

  // Zero divisor faults give zero velocities.
  `TLPD_ASSERT_NOW(a_fault_zero, out_valid && (fault == FAULT_ZERO_VZ || fault == FAULT_ZERO_F), new_vel_x == '0 && new_vel_y == '0 && new_vel_z == '0, "nonzero velocity on divisor fault")

endmodule

bind thin_lens_particle_deflect tlpd_checker u_tlpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (particle.ready),
  .out_valid (deflected.valid),
  .out_ready (deflected.ready),
  .new_vel_x (deflected.new_vel_x),
  .new_vel_y (deflected.new_vel_y),
  .new_vel_z (deflected.new_vel_z),
  .fault     (deflected.fault)
);
